/* rtl/lphm_pkg.sv */
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared constants, command and status codes and item types for the
// lfsr probed hash map unit.
// ----------------------------------------------------------------------------
package lphm_pkg;

  // slot count must be a power of two: the slot is the low bits of key + offset
  localparam int unsigned INDEX_SLOTS = 64;
  localparam int unsigned MAX_PROBES  = 64;
  localparam int unsigned LOAD_LIMIT  = (INDEX_SLOTS * 2) / 3;

  localparam int unsigned SLOT_W  = $clog2(INDEX_SLOTS);
  localparam int unsigned ENTRY_W = $clog2(INDEX_SLOTS + 1);
  localparam int unsigned PROBE_W = $clog2(MAX_PROBES);

  localparam logic [63:0] ZERO_KEY_OFFSET = 64'hDEAD_BEEF;

  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_GET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_FULL        = 2'd1;
  localparam logic [1:0] STATUS_PROBE_LIMIT = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [63:0] value;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [63:0] value_out;
    logic [1:0]  status;
    logic [5:0]  entry_total;
  } out_t;

endpackage

/* rtl/lfsr_probed_hash_map_unit.sv */
// ----------------------------------------------------------------------------
// lfsr_probed_hash_map_unit
// Compact open-addressing key-value map: set, get and clear commands, slot
// table pointing into an insertion-ordered entry store, LFSR probe sequence.
// ----------------------------------------------------------------------------
// One command is worked on at a time and the input is stalled meanwhile. A
// set or get probes occupied slots, up to MAX_PROBES of them, until it meets
// an empty slot, a matching key or the probe limit, then acts and offers its
// result item: each occupied slot costs a registered read of the slot index
// memory, then a registered read of the entry key and value memories, then
// the key compare. A clear or an unknown command goes from acceptance straight
// to its result. Clear empties the slot valid flags and the entry count on
// acceptance. A result that finds the output register still held by the
// receiver waits, and the input stays stalled with it. A new command may be
// accepted while the previous result still waits in the output register.
module lfsr_probed_hash_map_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lphm_pkg::in_t in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lphm_pkg::out_t out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_IDX,
    S_CMP,
    S_ACT,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    OC_EMPTY,
    OC_MATCH,
    OC_LIMIT
  } outcome_e;

  function automatic logic [63:0] lfsr_next(input logic [63:0] s);
    logic b;
    b = s[0] ^ s[1] ^ s[3] ^ s[4];
    return {b, s[63:1]};
  endfunction

  state_e                          state_q;
  outcome_e                        outcome_q;
  lphm_pkg::in_t                   item_q;
  logic [63:0]                     offset_q;
  logic [lphm_pkg::PROBE_W-1:0]    probe_cnt_q;
  logic [lphm_pkg::SLOT_W-1:0]     slot_q;
  logic [lphm_pkg::SLOT_W-1:0]     idx_q;
  logic [63:0]                     hit_value_q;
  logic [lphm_pkg::INDEX_SLOTS-1:0] slot_used_q;
  logic [lphm_pkg::ENTRY_W-1:0]    count_q;
  logic                            res_found_q;
  logic [63:0]                     res_value_q;
  logic [1:0]                      res_status_q;
  logic                            out_valid_q;
  lphm_pkg::out_t                  out_q;

  logic [lphm_pkg::SLOT_W-1:0] probe_slot;
  logic [lphm_pkg::SLOT_W-1:0] idx_rdata;
  logic [63:0]                 key_rdata;
  logic [63:0]                 val_rdata;
  logic [lphm_pkg::SLOT_W-1:0] entry_waddr;
  logic [lphm_pkg::SLOT_W-1:0] val_waddr;
  logic                        act_append;
  logic                        act_update;
  logic                        act_found;
  logic [63:0]                 act_value;
  logic [1:0]                  act_status;
  logic [63:0]                 init_offset;

  // slot is (key + offset) mod slot count: only the low bits matter
  assign probe_slot  = item_q.key[lphm_pkg::SLOT_W-1:0] + offset_q[lphm_pkg::SLOT_W-1:0];
  assign entry_waddr = count_q[lphm_pkg::SLOT_W-1:0];
  assign val_waddr   = (outcome_q == OC_MATCH) ? idx_q : entry_waddr;
  assign init_offset = (in_i.key != '0) ? in_i.key : lphm_pkg::ZERO_KEY_OFFSET;

  always_comb begin
    act_append = 1'b0;
    act_update = 1'b0;
    act_found  = 1'b0;
    act_value  = '0;
    act_status = lphm_pkg::STATUS_OK;
    if (outcome_q == OC_LIMIT) begin
      act_status = lphm_pkg::STATUS_PROBE_LIMIT;
    end else if (item_q.cmd == lphm_pkg::CMD_SET) begin
      act_found = (outcome_q == OC_MATCH);
      priority if (count_q >= lphm_pkg::ENTRY_W'(lphm_pkg::LOAD_LIMIT)) begin
        act_status = lphm_pkg::STATUS_FULL;
      end else if (outcome_q == OC_MATCH) begin
        act_update = 1'b1;
      end else if (count_q < lphm_pkg::ENTRY_W'(lphm_pkg::INDEX_SLOTS)) begin
        act_append = 1'b1;
      end else begin
        act_status = lphm_pkg::STATUS_FULL;
      end
    end else if (outcome_q == OC_MATCH) begin
      act_found = 1'b1;
      act_value = hit_value_q;
    end
  end

  lphm_ram #(
    .WIDTH(lphm_pkg::SLOT_W),
    .DEPTH(lphm_pkg::INDEX_SLOTS)
  ) u_slot_index (
    .clk_i  (clk_i),
    .we_i   ((state_q == S_ACT) && act_append),
    .waddr_i(slot_q),
    .wdata_i(entry_waddr),
    .raddr_i(probe_slot),
    .rdata_o(idx_rdata)
  );

  lphm_ram #(
    .WIDTH(64),
    .DEPTH(lphm_pkg::INDEX_SLOTS)
  ) u_entry_key (
    .clk_i  (clk_i),
    .we_i   ((state_q == S_ACT) && act_append),
    .waddr_i(entry_waddr),
    .wdata_i(item_q.key),
    .raddr_i(idx_rdata),
    .rdata_o(key_rdata)
  );

  lphm_ram #(
    .WIDTH(64),
    .DEPTH(lphm_pkg::INDEX_SLOTS)
  ) u_entry_value (
    .clk_i  (clk_i),
    .we_i   ((state_q == S_ACT) && (act_append || act_update)),
    .waddr_i(val_waddr),
    .wdata_i(item_q.value),
    .raddr_i(idx_rdata),
    .rdata_o(val_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_used_q <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // in the response state the output register is handled below
      if (out_valid_q && !out_stall_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q       <= in_i;
            offset_q     <= init_offset;
            probe_cnt_q  <= '0;
            res_found_q  <= 1'b0;
            res_value_q  <= '0;
            res_status_q <= lphm_pkg::STATUS_OK;
            priority if (in_i.cmd == lphm_pkg::CMD_SET || in_i.cmd == lphm_pkg::CMD_GET) begin
              state_q <= S_PROBE;
            end else if (in_i.cmd == lphm_pkg::CMD_CLEAR) begin
              slot_used_q <= '0;
              count_q     <= '0;
              state_q     <= S_RESP;
            end else begin
              state_q <= S_RESP;
            end
          end
        end
        S_PROBE: begin
          slot_q <= probe_slot;
          if (!slot_used_q[probe_slot]) begin
            outcome_q <= OC_EMPTY;
            state_q   <= S_ACT;
          end else begin
            state_q <= S_IDX;
          end
        end
        S_IDX: begin
          idx_q   <= idx_rdata;
          state_q <= S_CMP;
        end
        S_CMP: begin
          priority if (key_rdata == item_q.key) begin
            outcome_q   <= OC_MATCH;
            hit_value_q <= val_rdata;
            state_q     <= S_ACT;
          end else if (probe_cnt_q == lphm_pkg::PROBE_W'(lphm_pkg::MAX_PROBES - 1)) begin
            outcome_q <= OC_LIMIT;
            state_q   <= S_ACT;
          end else begin
            offset_q    <= lfsr_next(offset_q);
            probe_cnt_q <= probe_cnt_q + 1'b1;
            state_q     <= S_PROBE;
          end
        end
        S_ACT: begin
          res_found_q  <= act_found;
          res_value_q  <= act_value;
          res_status_q <= act_status;
          if (act_append) begin
            slot_used_q[slot_q] <= 1'b1;
            count_q             <= count_q + 1'b1;
          end
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.found       <= res_found_q;
            out_q.value_out   <= res_value_q;
            out_q.status      <= res_status_q;
            out_q.entry_total <= count_q[5:0];
            out_valid_q       <= 1'b1;
            state_q           <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // the entry store never grows past the load limit
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lphm_pkg::ENTRY_W'(lphm_pkg::LOAD_LIMIT))
    else $error("entry count above load limit");

  // an accepted item always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != S_IDLE)
    else $error("accepted item did not leave idle");

  // a probe-limit result never reports a hit
  a_limit_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == lphm_pkg::STATUS_PROBE_LIMIT) |-> !out_o.found)
    else $error("probe limit with found set");

  // value only comes out on a hit
  a_value_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.found |-> out_o.value_out == '0)
    else $error("value out without a hit");

  // the count only moves when a set appends or a clear empties the map
  a_count_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_ACT) && !(state_q == S_IDLE && in_valid_i) |=> $stable(count_q))
    else $error("entry count changed outside append or clear");

endmodule

/* rtl/lphm_ram.sv */
// ----------------------------------------------------------------------------
// lphm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lphm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lfsr probed hash map unit: a directed opening
// (zero and all-ones keys, overwrite, unknown command, clear, probe limit),
// then random fill-and-clear runs that reach the load limit, checked against
// an in-bench model of the map with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lphm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned RAND_ITEMS   = 880;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned POOL_DEPTH   = 64;

  typedef enum logic [1:0] {PROBE_FREE, PROBE_HIT, PROBE_LIMIT} probe_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;

  // model of the map
  logic              slot_busy  [INDEX_SLOTS];
  logic [SLOT_W-1:0] slot_entry [INDEX_SLOTS];
  logic [63:0]       ent_key    [INDEX_SLOTS];
  logic [63:0]       ent_val    [INDEX_SLOTS];
  int unsigned       ent_count = 0;

  in_t         cmd_q[$];
  out_t        reply_q[$];
  logic [63:0] key_pool[$];

  int unsigned total_items = 0;
  int unsigned accepted_cnt = 0;
  int unsigned reply_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          in_taken = 1'b0;

  lfsr_probed_hash_map_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic probe_e probe_map(input logic [63:0] key, output logic [SLOT_W-1:0] slot);
    logic [63:0] offset;
    logic [63:0] sum;
    offset = (key != '0) ? key : ZERO_KEY_OFFSET;
    slot = '0;
    for (int n = 0; n < MAX_PROBES; n++) begin
      sum = key + offset;
      if (!slot_busy[sum[SLOT_W-1:0]]) begin
        slot = sum[SLOT_W-1:0];
        return PROBE_FREE;
      end
      if (ent_key[slot_entry[sum[SLOT_W-1:0]]] == key) begin
        slot = sum[SLOT_W-1:0];
        return PROBE_HIT;
      end
      offset = {offset[0] ^ offset[1] ^ offset[3] ^ offset[4], offset[63:1]};
    end
    return PROBE_LIMIT;
  endfunction

  function automatic out_t map_apply(input in_t item);
    out_t res;
    probe_e hit;
    logic [SLOT_W-1:0] slot;
    res = '0;
    case (item.cmd)
      CMD_SET: begin
        hit = probe_map(item.key, slot);
        if (hit == PROBE_LIMIT) begin
          res.status = STATUS_PROBE_LIMIT;
        end else begin
          res.found = (hit == PROBE_HIT);
          if (ent_count >= LOAD_LIMIT) begin
            res.status = STATUS_FULL;
          end else if (hit == PROBE_HIT) begin
            ent_val[slot_entry[slot]] = item.value;
          end else if (ent_count < INDEX_SLOTS) begin
            slot_busy[slot] = 1'b1;
            slot_entry[slot] = SLOT_W'(ent_count);
            ent_key[ent_count] = item.key;
            ent_val[ent_count] = item.value;
            ent_count++;
          end else begin
            res.status = STATUS_FULL;
          end
        end
      end
      CMD_GET: begin
        hit = probe_map(item.key, slot);
        if (hit == PROBE_LIMIT) begin
          res.status = STATUS_PROBE_LIMIT;
        end else if (hit == PROBE_HIT) begin
          res.found = 1'b1;
          res.value_out = ent_val[slot_entry[slot]];
        end
      end
      CMD_CLEAR: begin
        foreach (slot_busy[i]) slot_busy[i] = 1'b0;
        ent_count = 0;
      end
      default: begin
      end
    endcase
    res.entry_total = 6'(ent_count);
    return res;
  endfunction

  // keys 32, 1, 3, 7, 15 and 31 sit on every slot that the all-ones key probes
  function automatic logic [63:0] trap_key(input int unsigned idx);
    case (idx)
      0: return 64'd32;
      1: return 64'd1;
      2: return 64'd3;
      3: return 64'd7;
      4: return 64'd15;
      5: return 64'd31;
      default: return '1;
    endcase
  endfunction

  function automatic logic [63:0] fresh_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return trap_key($urandom_range(0, 6));
      2, 3: return 64'($urandom_range(0, 255));
      4: return {32'hFFFF_FFFF, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] pool_or_fresh(input int unsigned pool_pct);
    if (key_pool.size() > 0 && $urandom_range(0, 99) < pool_pct)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return fresh_key();
  endfunction

  task automatic push_cmd(input logic [1:0] cmd, input logic [63:0] key, input logic [63:0] value);
    in_t item;
    item.cmd = cmd;
    item.key = key;
    item.value = value;
    cmd_q.push_back(item);
    if (cmd == CMD_SET) begin
      key_pool.push_back(key);
      if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
    end
  endtask

  function automatic int unsigned send_idle_pct();
    case (accepted_cnt * 3 / total_items)
      0: return 30;
      1: return 52;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_idle_pct();
    case (accepted_cnt * 3 / total_items)
      0: return 52;
      1: return 30;
      default: return 0;
    endcase
  endfunction

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (cmd_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
        in_i <= cmd_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off halfway through so the unit backs up
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (rst_ni && !hold_done && accepted_cnt >= total_items / 2) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct());
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_t want;
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      reply_cnt++;
      if (reply_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result: found=%0b value=%h status=%0d total=%0d",
                   out_o.found, out_o.value_out, out_o.status, out_o.entry_total);
      end else begin
        want = reply_q.pop_front();
        if (out_o.found !== want.found || out_o.value_out !== want.value_out ||
            out_o.status !== want.status || out_o.entry_total !== want.entry_total) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result %0d: expected found=%0b value=%h status=%0d total=%0d, got found=%0b value=%h status=%0d total=%0d",
                     reply_cnt, want.found, want.value_out, want.status, want.entry_total,
                     out_o.found, out_o.value_out, out_o.status, out_o.entry_total);
        end
      end
    end
    if (in_taken) begin
      reply_q.push_back(map_apply(in_i));
      accepted_cnt++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("lfsr_probed_hash_map_unit: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned set_pct;
    int unsigned run_len;
    int unsigned pick;
    int unsigned rand_cnt;
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;

    // zero key, all-ones key, overwrite, miss, unknown command, clear
    push_cmd(CMD_SET, '0, 64'h0123_4567_89AB_CDEF);
    push_cmd(CMD_GET, '0, '1);
    push_cmd(CMD_SET, '1, '1);
    push_cmd(CMD_GET, '1, '0);
    push_cmd(CMD_GET, 64'h8000_0000_0000_0005, '0);
    push_cmd(CMD_SET, '0, '0);
    push_cmd(CMD_GET, '0, 64'h8000_0000_0000_0000);
    push_cmd(CMD_UNUSED, '1, '1);
    push_cmd(CMD_CLEAR, '1, '1);
    push_cmd(CMD_GET, '0, '0);
    // block every slot on the all-ones key's probe path
    for (int i = 0; i < 6; i++) push_cmd(CMD_SET, trap_key(i), {$urandom, $urandom});
    push_cmd(CMD_GET, '1, '0);
    push_cmd(CMD_SET, '1, 64'h5555_AAAA_5555_AAAA);
    push_cmd(CMD_GET, 64'd31, '0);
    push_cmd(CMD_CLEAR, '0, '0);

    // runs of random commands, each closed by a clear; set-heavy runs fill up
    rand_cnt = 0;
    while (rand_cnt < RAND_ITEMS) begin
      set_pct = $urandom_range(30, 85);
      run_len = $urandom_range(20, 120);
      for (int i = 0; i < run_len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < set_pct)
          push_cmd(CMD_SET, pool_or_fresh(25), {$urandom, $urandom});
        else if (pick < 97)
          push_cmd(CMD_GET, pool_or_fresh(75), {$urandom, $urandom});
        else
          push_cmd(CMD_UNUSED, {$urandom, $urandom}, {$urandom, $urandom});
      end
      push_cmd(CMD_CLEAR, {$urandom, $urandom}, {$urandom, $urandom});
      rand_cnt += run_len + 1;
    end
    total_items = cmd_q.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_cnt == total_items && reply_cnt >= total_items);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && reply_q.size() == 0) begin
      $display("lfsr_probed_hash_map_unit: match");
    end else begin
      $display("lfsr_probed_hash_map_unit: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lphm_pkg.sv
rtl/lphm_ram.sv
rtl/lfsr_probed_hash_map_unit.sv
tb/sv/tb_top.sv
